>>> design/csq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csq_pkg;

    localparam int MAX_POINTS_DEF = 256;

    localparam logic [2:0] FUNC_CLEAR   = 3'd0;
    localparam logic [2:0] FUNC_APPEND  = 3'd1;
    localparam logic [2:0] FUNC_SUPPORT = 3'd2;
    localparam logic [2:0] FUNC_BOUNDS  = 3'd3;
    localparam logic [2:0] FUNC_SPEED   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] REG_SHAPE_VALID = 2'd0;
    localparam logic [1:0] REG_COM_X       = 2'd1;
    localparam logic [1:0] REG_COM_Y       = 2'd2;
    localparam logic [1:0] REG_COM_Z       = 2'd3;

    typedef struct packed {
        logic        [2:0]  func;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] bias;
    } csq_req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] box_hi_x;
        logic signed [31:0] box_hi_y;
        logic signed [31:0] box_hi_z;
        logic        [30:0] speed;
        logic        [1:0]  status;
    } csq_res_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_SUPPORT,
        OP_BOUNDS,
        OP_SPEED,
        OP_NOP
    } csq_op_t;

    typedef struct packed {
        csq_op_t  op;
        csq_req_t req;
    } csq_cmd_t;

    typedef struct packed {
        logic     valid;
        csq_cmd_t cmd;
    } csq_q_t;

    typedef struct packed {
        logic               shape_valid;
        logic signed [31:0] com_x;
        logic signed [31:0] com_y;
        logic signed [31:0] com_z;
    } csq_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QUAT,
        S_MAT,
        S_RD,
        S_XF,
        S_BND,
        S_SP,
        S_DOT,
        S_SQ,
        S_SQRT,
        S_BMUL,
        S_DIV
    } csq_state_t;

endpackage

`default_nettype wire

>>> design/convex_shape_support_query.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake               payload
// request   in         start && !busy          request (csq_req_t)
// result    out        done, one-cycle strobe  result (csq_res_t)
// config    in         APB write, pready = 1   pwdata -> register paddr[3:2]
//
// Clear, append, unknown-function and rejected queries: result in the cycle after the request leaves the queue.
// Support, bounds and speed queries walk their steps on one shared 33x33 multiplier; support and
// speed visit every stored point, and support also uses the bit-per-cycle square root and the
// 64-step divider for the bias offset.
// Reset is asynchronous, active low; the point store is not cleared.
// A two-entry request queue decouples acceptance; busy is high while it is full.
// Results cannot be stalled by the receiver.
module convex_shape_support_query
    import csq_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire csq_req_t    request,
    output logic             done,
    output csq_res_t         result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    csq_cfg_t cfg_reg;
    csq_q_t   head;
    logic     pop;
    logic     cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_SHAPE_VALID: cfg_reg.shape_valid <= pwdata[0];
                REG_COM_X:       cfg_reg.com_x       <= pwdata;
                REG_COM_Y:       cfg_reg.com_y       <= pwdata;
                REG_COM_Z:       cfg_reg.com_z       <= pwdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SHAPE_VALID: prdata = {31'b0, cfg_reg.shape_valid};
            REG_COM_X:       prdata = cfg_reg.com_x;
            REG_COM_Y:       prdata = cfg_reg.com_y;
            REG_COM_Z:       prdata = cfg_reg.com_z;
            default:         prdata = '0;
        endcase
    end

    csq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .head    (head),
        .pop     (pop)
    );

    csq_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .cfg    (cfg_reg),
        .done   (done),
        .result (result)
    );

`ifndef SYNTHESIS
    a_cfg_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && paddr[3:2] == REG_SHAPE_VALID) |=> (cfg_reg.shape_valid == $past(pwdata[0])))
        else $error("shape_valid register not written");

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_INVALID) |-> (result.speed == '0 && result.out_x == '0
            && result.box_hi_x == '0))
        else $error("rejected query carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status != 2'd3))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire

>>> design/csq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module csq_front
    import csq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire csq_req_t request,
    output logic          busy,
    output csq_q_t        head,
    input  wire logic     pop
);

    csq_cmd_t   ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    csq_op_t    op_dec;

    always_comb
    begin
        unique case (request.func)
            FUNC_CLEAR:   op_dec = OP_CLEAR;
            FUNC_APPEND:  op_dec = OP_APPEND;
            FUNC_SUPPORT: op_dec = OP_SUPPORT;
            FUNC_BOUNDS:  op_dec = OP_BOUNDS;
            FUNC_SPEED:   op_dec = OP_SPEED;
            default:      op_dec = OP_NOP;
        endcase
    end

    assign busy       = (cnt_reg == 2'd2);
    assign push       = start && !busy;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.cmd   = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg].op  <= op_dec;
            ent_reg[wr_ptr_reg].req <= request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/csq_back.sv
`timescale 1ns / 1ps
`default_nettype none

module csq_back
    import csq_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire csq_q_t   head,
    output logic          pop,
    input  wire csq_cfg_t cfg,
    output logic          done,
    output csq_res_t      result
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
    localparam logic signed [67:0] RND30 = 68'sd536870912;
    localparam logic signed [67:0] RND16 = 68'sd32768;
    localparam logic signed [67:0] Q30_ONE = 68'sd1073741824;
    localparam logic signed [67:0] SPD_MAX = 68'sd2147483647;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -68'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [1:0] xf_col(input logic [3:0] s);
        logic [1:0] c;
        case (s) inside
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] xf_row(input logic [3:0] s);
        logic [1:0] r;
        case (s) inside
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    csq_state_t         state_reg, state_next;
    csq_cmd_t           cmd_reg;
    logic [3:0]         step_reg;
    logic               ph_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      count_reg;
    logic signed [31:0] bmin_reg [3];
    logic signed [31:0] bmax_reg [3];
    logic signed [33:0] q_reg [9];
    logic signed [31:0] m_reg [9];
    logic signed [31:0] cur_reg [3];
    logic signed [65:0] acc_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] best_dot_reg;
    logic signed [31:0] best_pt_reg [3];
    logic [30:0]        spd_best_reg;
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic [2:0]         corner_reg;
    logic [63:0]        nrem_reg;
    logic [63:0]        rt_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        len_reg;
    logic [5:0]         cnt_reg;
    logic [1:0]         comp_reg;
    logic [63:0]        dvd_reg;
    logic [32:0]        rem_reg;
    csq_res_t           res_reg;
    logic               done_reg;
    logic [95:0]        store_reg [MAX_POINTS];
    logic [95:0]        rd_reg;

    logic signed [31:0] a_v [3];
    logic signed [31:0] b_v [3];
    logic signed [31:0] v_v [3];
    logic signed [31:0] r_v [3];
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] sum_c;
    logic               sub;
    logic [1:0]         col, row;
    logic [CW-1:0]      idx_inc;
    logic               last_pt;
    logic               invalid;
    logic               mem_we;
    logic [30:0]        spd_s, spd_new;
    logic signed [67:0] spd_t;
    logic signed [31:0] lo_n [3];
    logic signed [31:0] hi_n [3];
    logic [63:0]        sq_try;
    logic [63:0]        rt_next;
    logic [32:0]        rem_sh;
    logic               qbit;
    logic [63:0]        q_fin;
    logic signed [67:0] off_s;
    logic               neg;
    logic signed [31:0] sup_out;

    assign a_v[0] = cmd_reg.req.a_x;
    assign a_v[1] = cmd_reg.req.a_y;
    assign a_v[2] = cmd_reg.req.a_z;
    assign b_v[0] = cmd_reg.req.b_x;
    assign b_v[1] = cmd_reg.req.b_y;
    assign b_v[2] = cmd_reg.req.b_z;

    assign col     = xf_col(step_reg);
    assign row     = xf_row(step_reg);
    assign idx_inc = idx_reg + CW'(1);
    assign last_pt = (idx_inc == count_reg);
    assign invalid = !cfg.shape_valid || (count_reg == '0);
    assign mem_we  = (state_reg == S_IDLE) && head.valid && (head.cmd.op == OP_APPEND)
                     && (count_reg < CNT_MAX);

    always_comb
    begin
        if (cmd_reg.op == OP_BOUNDS)
        begin
            v_v[0] = corner_reg[0] ? bmax_reg[0] : bmin_reg[0];
            v_v[1] = corner_reg[1] ? bmax_reg[1] : bmin_reg[1];
            v_v[2] = corner_reg[2] ? bmax_reg[2] : bmin_reg[2];
        end
        else
        begin
            v_v[0] = rd_reg[95:64];
            v_v[1] = rd_reg[63:32];
            v_v[2] = rd_reg[31:0];
        end
    end

    // point relative to centre of mass
    assign r_v[0] = sat32(68'(v_v[0]) - 68'(cfg.com_x));
    assign r_v[1] = sat32(68'(v_v[1]) - 68'(cfg.com_y));
    assign r_v[2] = sat32(68'(v_v[2]) - 68'(cfg.com_z));

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_QUAT:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_x); mul_b = 33'(cmd_reg.req.quat_x);
                    end
                    4'd1:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_y); mul_b = 33'(cmd_reg.req.quat_y);
                    end
                    4'd2:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_z); mul_b = 33'(cmd_reg.req.quat_z);
                    end
                    4'd3:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_x); mul_b = 33'(cmd_reg.req.quat_y);
                    end
                    4'd4:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_x); mul_b = 33'(cmd_reg.req.quat_z);
                    end
                    4'd5:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_y); mul_b = 33'(cmd_reg.req.quat_z);
                    end
                    4'd6:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_w); mul_b = 33'(cmd_reg.req.quat_x);
                    end
                    4'd7:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_w); mul_b = 33'(cmd_reg.req.quat_y);
                    end
                    default:
                    begin
                        mul_a = 33'(cmd_reg.req.quat_w); mul_b = 33'(cmd_reg.req.quat_z);
                    end
                endcase
            end
            S_XF:
            begin
                mul_a = 33'(m_reg[step_reg]);
                mul_b = 33'(v_v[col]);
            end
            S_DOT:
            begin
                mul_a = 33'(a_v[step_reg[1:0]]);
                mul_b = 33'(cur_reg[step_reg[1:0]]);
            end
            S_SQ:
            begin
                mul_a = 33'(a_v[step_reg[1:0]]);
                mul_b = 33'(a_v[step_reg[1:0]]);
            end
            S_SP:
            begin
                case (step_reg)
                    4'd0:    begin mul_a = 33'(b_v[1]); mul_b = 33'(r_v[2]); end
                    4'd1:    begin mul_a = 33'(b_v[2]); mul_b = 33'(r_v[1]); end
                    4'd2:    begin mul_a = 33'(b_v[2]); mul_b = 33'(r_v[0]); end
                    4'd3:    begin mul_a = 33'(b_v[0]); mul_b = 33'(r_v[2]); end
                    4'd4:    begin mul_a = 33'(b_v[0]); mul_b = 33'(r_v[1]); end
                    default: begin mul_a = 33'(b_v[1]); mul_b = 33'(r_v[0]); end
                endcase
            end
            S_BMUL:
            begin
                // magnitudes, unsigned product
                mul_a = a_v[comp_reg][31] ? -33'(a_v[comp_reg]) : 33'(a_v[comp_reg]);
                mul_b = cmd_reg.req.bias[31] ? -33'(cmd_reg.req.bias)
                                             : 33'(cmd_reg.req.bias);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign sub   = (state_reg == S_SP) && step_reg[0];
    assign sum_c = sub ? (acc_reg - prod_reg) : (acc_reg + prod_reg);

    // speed candidate from the finished dot product
    assign spd_t = (68'(sum_c) + RND16) >>> 16;
    always_comb
    begin
        if (sum_c < 0)
        begin
            spd_s = '0;
        end
        else if (spd_t > SPD_MAX)
        begin
            spd_s = 31'h7fffffff;
        end
        else
        begin
            spd_s = spd_t[30:0];
        end
        spd_new = (spd_s > spd_best_reg) ? spd_s : spd_best_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_n[k] = ((corner_reg == 3'd0) || (cur_reg[k] < lo_reg[k])) ? cur_reg[k]
                                                                          : lo_reg[k];
            hi_n[k] = ((corner_reg == 3'd0) || (cur_reg[k] > hi_reg[k])) ? cur_reg[k]
                                                                          : hi_reg[k];
        end
    end

    assign sq_try  = rt_reg + bit_reg;
    assign rt_next = (nrem_reg >= sq_try) ? ((rt_reg >> 1) + bit_reg) : (rt_reg >> 1);

    assign rem_sh = {rem_reg[31:0], dvd_reg[63]};
    assign qbit   = (rem_sh >= {1'b0, len_reg});
    assign q_fin  = {dvd_reg[62:0], qbit};
    assign neg    = a_v[comp_reg][31] != cmd_reg.req.bias[31];
    assign off_s  = neg ? -$signed({4'b0, q_fin}) : $signed({4'b0, q_fin});
    assign sup_out = sat32(68'(best_pt_reg[comp_reg]) + off_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (!invalid)
                    begin
                        if (head.cmd.op == OP_SUPPORT || head.cmd.op == OP_BOUNDS)
                        begin
                            state_next = S_QUAT;
                        end
                        else if (head.cmd.op == OP_SPEED)
                        begin
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_QUAT:
            begin
                if (ph_reg && step_reg == 4'd8)
                begin
                    state_next = S_MAT;
                end
            end
            S_MAT:
            begin
                state_next = (cmd_reg.op == OP_SUPPORT) ? S_RD : S_XF;
            end
            S_RD:
            begin
                state_next = (cmd_reg.op == OP_SPEED) ? S_SP : S_XF;
            end
            S_XF:
            begin
                if (ph_reg && step_reg == 4'd8)
                begin
                    state_next = (cmd_reg.op == OP_SUPPORT) ? S_DOT : S_BND;
                end
            end
            S_BND:
            begin
                state_next = (corner_reg == 3'd7) ? S_IDLE : S_XF;
            end
            S_SP:
            begin
                if (ph_reg && step_reg == 4'd5)
                begin
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                if (ph_reg && step_reg == 4'd2)
                begin
                    if (!last_pt)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = (cmd_reg.op == OP_SUPPORT) ? S_SQ : S_IDLE;
                    end
                end
            end
            S_SQ:
            begin
                if (ph_reg && step_reg == 4'd2)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (cnt_reg == 6'd31)
                begin
                    state_next = S_BMUL;
                end
            end
            S_BMUL:
            begin
                if (len_reg == '0)
                begin
                    if (comp_reg == 2'd2)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (ph_reg)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = (comp_reg == 2'd2) ? S_IDLE : S_BMUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[count_reg[AW-1:0]] <= {head.cmd.req.a_x, head.cmd.req.a_y,
                                             head.cmd.req.a_z};
        end
        rd_reg <= store_reg[idx_reg[AW-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            count_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                bmin_reg[k] <= 32'sh7fffffff;
                bmax_reg[k] <= 32'sh80000000;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        case (head.cmd.op)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                for (int k = 0; k < 3; k++)
                                begin
                                    bmin_reg[k] <= 32'sh7fffffff;
                                    bmax_reg[k] <= 32'sh80000000;
                                end
                                done_reg <= 1'b1;
                            end
                            OP_APPEND:
                            begin
                                if (mem_we)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                    if (head.cmd.req.a_x < bmin_reg[0])
                                        bmin_reg[0] <= head.cmd.req.a_x;
                                    if (head.cmd.req.a_y < bmin_reg[1])
                                        bmin_reg[1] <= head.cmd.req.a_y;
                                    if (head.cmd.req.a_z < bmin_reg[2])
                                        bmin_reg[2] <= head.cmd.req.a_z;
                                    if (head.cmd.req.a_x > bmax_reg[0])
                                        bmax_reg[0] <= head.cmd.req.a_x;
                                    if (head.cmd.req.a_y > bmax_reg[1])
                                        bmax_reg[1] <= head.cmd.req.a_y;
                                    if (head.cmd.req.a_z > bmax_reg[2])
                                        bmax_reg[2] <= head.cmd.req.a_z;
                                end
                                done_reg <= 1'b1;
                            end
                            OP_NOP:
                            begin
                                done_reg <= 1'b1;
                            end
                            default:
                            begin
                                done_reg <= invalid;
                            end
                        endcase
                    end
                end
                S_BND:
                begin
                    done_reg <= (corner_reg == 3'd7);
                end
                S_DOT:
                begin
                    done_reg <= ph_reg && (step_reg == 4'd2) && last_pt
                                && (cmd_reg.op == OP_SPEED);
                end
                S_BMUL:
                begin
                    done_reg <= (len_reg == '0) && (comp_reg == 2'd2);
                end
                S_DIV:
                begin
                    done_reg <= (cnt_reg == 6'd63) && (comp_reg == 2'd2);
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg      <= head.cmd;
                step_reg     <= '0;
                ph_reg       <= 1'b0;
                idx_reg      <= '0;
                corner_reg   <= '0;
                acc_reg      <= '0;
                comp_reg     <= '0;
                spd_best_reg <= '0;
                res_reg      <= '0;
                if (head.valid)
                begin
                    if (head.cmd.op == OP_APPEND && !mem_we)
                    begin
                        res_reg.status <= ST_FULL;
                    end
                    else if ((head.cmd.op == OP_SUPPORT || head.cmd.op == OP_BOUNDS
                              || head.cmd.op == OP_SPEED) && invalid)
                    begin
                        res_reg.status <= ST_INVALID;
                    end
                end
            end
            S_QUAT:
            begin
                if (!ph_reg)
                begin
                    prod_reg <= mul_p;
                    ph_reg   <= 1'b1;
                end
                else
                begin
                    q_reg[step_reg] <= 34'((68'(prod_reg) + RND30) >>> 30);
                    step_reg        <= step_reg + 4'd1;
                    ph_reg          <= 1'b0;
                end
            end
            S_MAT:
            begin
                m_reg[0] <= sat32(Q30_ONE - 2 * (68'(q_reg[1]) + 68'(q_reg[2])));
                m_reg[1] <= sat32(2 * (68'(q_reg[3]) - 68'(q_reg[8])));
                m_reg[2] <= sat32(2 * (68'(q_reg[4]) + 68'(q_reg[7])));
                m_reg[3] <= sat32(2 * (68'(q_reg[3]) + 68'(q_reg[8])));
                m_reg[4] <= sat32(Q30_ONE - 2 * (68'(q_reg[0]) + 68'(q_reg[2])));
                m_reg[5] <= sat32(2 * (68'(q_reg[5]) - 68'(q_reg[6])));
                m_reg[6] <= sat32(2 * (68'(q_reg[4]) - 68'(q_reg[7])));
                m_reg[7] <= sat32(2 * (68'(q_reg[5]) + 68'(q_reg[6])));
                m_reg[8] <= sat32(Q30_ONE - 2 * (68'(q_reg[0]) + 68'(q_reg[1])));
                step_reg <= '0;
                ph_reg   <= 1'b0;
                acc_reg  <= '0;
            end
            S_RD:
            begin
                step_reg <= '0;
                ph_reg   <= 1'b0;
                acc_reg  <= '0;
            end
            S_XF:
            begin
                if (!ph_reg)
                begin
                    prod_reg <= mul_p;
                    ph_reg   <= 1'b1;
                end
                else
                begin
                    ph_reg <= 1'b0;
                    if (col == 2'd2)
                    begin
                        cur_reg[row] <= sat32(((68'(sum_c) + RND30) >>> 30) + 68'(b_v[row]));
                        acc_reg      <= '0;
                    end
                    else
                    begin
                        acc_reg <= sum_c;
                    end
                    step_reg <= (step_reg == 4'd8) ? 4'd0 : step_reg + 4'd1;
                end
            end
            S_BND:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lo_reg[k] <= lo_n[k];
                    hi_reg[k] <= hi_n[k];
                end
                corner_reg <= corner_reg + 3'd1;
                res_reg.out_x    <= lo_n[0];
                res_reg.out_y    <= lo_n[1];
                res_reg.out_z    <= lo_n[2];
                res_reg.box_hi_x <= hi_n[0];
                res_reg.box_hi_y <= hi_n[1];
                res_reg.box_hi_z <= hi_n[2];
            end
            S_SP:
            begin
                if (!ph_reg)
                begin
                    prod_reg <= mul_p;
                    ph_reg   <= 1'b1;
                end
                else
                begin
                    ph_reg <= 1'b0;
                    if (step_reg[0])
                    begin
                        cur_reg[step_reg[2:1]] <= sat32((68'(sum_c) + RND16) >>> 16);
                        acc_reg                <= '0;
                    end
                    else
                    begin
                        acc_reg <= sum_c;
                    end
                    step_reg <= (step_reg == 4'd5) ? 4'd0 : step_reg + 4'd1;
                end
            end
            S_DOT:
            begin
                if (!ph_reg)
                begin
                    prod_reg <= mul_p;
                    ph_reg   <= 1'b1;
                end
                else
                begin
                    ph_reg <= 1'b0;
                    if (step_reg == 4'd2)
                    begin
                        // first point wins ties
                        if (idx_reg == '0 || sum_c > best_dot_reg)
                        begin
                            best_dot_reg <= sum_c;
                            for (int k = 0; k < 3; k++)
                            begin
                                best_pt_reg[k] <= cur_reg[k];
                            end
                        end
                        spd_best_reg  <= spd_new;
                        res_reg.speed <= (cmd_reg.op == OP_SPEED) ? spd_new : '0;
                        acc_reg       <= '0;
                        step_reg      <= '0;
                        idx_reg       <= idx_inc;
                    end
                    else
                    begin
                        acc_reg  <= sum_c;
                        step_reg <= step_reg + 4'd1;
                    end
                end
            end
            S_SQ:
            begin
                if (!ph_reg)
                begin
                    prod_reg <= mul_p;
                    ph_reg   <= 1'b1;
                end
                else
                begin
                    ph_reg <= 1'b0;
                    if (step_reg == 4'd2)
                    begin
                        nrem_reg <= sum_c[63:0];
                        rt_reg   <= '0;
                        bit_reg  <= 64'h4000_0000_0000_0000;
                        cnt_reg  <= '0;
                        acc_reg  <= '0;
                    end
                    else
                    begin
                        acc_reg  <= sum_c;
                        step_reg <= step_reg + 4'd1;
                    end
                end
            end
            S_SQRT:
            begin
                if (nrem_reg >= sq_try)
                begin
                    nrem_reg <= nrem_reg - sq_try;
                end
                rt_reg  <= rt_next;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 6'd1;
                len_reg <= rt_next[31:0];
                comp_reg <= '0;
                ph_reg   <= 1'b0;
            end
            S_BMUL:
            begin
                if (len_reg == '0)
                begin
                    case (comp_reg)
                        2'd0:    res_reg.out_x <= best_pt_reg[0];
                        2'd1:    res_reg.out_y <= best_pt_reg[1];
                        default: res_reg.out_z <= best_pt_reg[2];
                    endcase
                    comp_reg <= comp_reg + 2'd1;
                end
                else if (!ph_reg)
                begin
                    prod_reg <= mul_p;
                    ph_reg   <= 1'b1;
                end
                else
                begin
                    dvd_reg <= prod_reg[63:0] + {33'b0, len_reg[31:1]};
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    ph_reg  <= 1'b0;
                end
            end
            S_DIV:
            begin
                rem_reg <= qbit ? (rem_sh - {1'b0, len_reg}) : rem_sh;
                dvd_reg <= q_fin;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    case (comp_reg)
                        2'd0:    res_reg.out_x <= sup_out;
                        2'd1:    res_reg.out_y <= sup_out;
                        default: res_reg.out_z <= sup_out;
                    endcase
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            default:
            begin
                ph_reg <= 1'b0;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire
